// ----- sv/ltdf_pkg.sv -----
// Shared types, character codes and denylist table for the log tag filter.
`timescale 1ns / 1ps

package ltdf_pkg;

    typedef enum logic [1:0] {
        PH_SEEK_PAREN = 2'd0,
        PH_SAW_PAREN  = 2'd1,
        PH_IN_TAG     = 2'd2,
        PH_DONE       = 2'd3
    } phase_t;

    localparam int DENY_ROWS = 4;
    localparam int ROW_CHARS = 16;
    localparam int ENTRY_W   = 2;
    localparam int POS_W     = 6;

    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_COLON   = 8'h3a;
    localparam logic [7:0] CH_NEWLINE = 8'h0a;
    localparam logic [7:0] CH_NUL     = 8'h00;

    localparam logic [POS_W-1:0] DENY_LEN [DENY_ROWS] = '{6'd11, 6'd10, 6'd4, 6'd10};

    localparam logic [7:0] DENY_TEXT [DENY_ROWS][ROW_CHARS] = '{
        '{"s", "c", "e", "p", "_", "e", "n", "r", "o", "l", "l",
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"c", "e", "r", "t", "_", "r", "e", "n", "e", "w",
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"w", "i", "f", "i",
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00},
        '{"s", "s", "h", "_", "s", "e", "r", "v", "e", "r",
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    function automatic logic is_terminator(logic [7:0] b);
        return (b == CH_COLON) || (b == CH_SPACE) || (b == CH_NEWLINE) || (b == CH_NUL);
    endfunction

    // true if entry row still matches with byte b at tag position pos
    function automatic logic deny_keep(logic [ENTRY_W-1:0] row, logic [POS_W-1:0] pos,
                                       logic [7:0] b);
        logic in_len;
        in_len = pos < DENY_LEN[row];
        return in_len && (DENY_TEXT[row][pos[3:0]] == b);
    endfunction

endpackage

// ----- sv/log_tag_denylist_filter_core.sv -----
// Log tag denylist filter: scans a log line byte by byte and flags denylisted tags.
`timescale 1ns / 1ps

// Takes one byte of a log line per cycle on the slave stream (s_tlast marks the
// line's last byte) and, for each line, returns one result word on the master
// stream when that last byte is taken. The tag is the text after the first ") "
// pair up to ':', space, newline or NUL; the line is blocked when the tag is
// 1 to TAG_LIMIT-1 bytes, terminated inside the line and equal to a denylist
// entry (lowest entry wins). Bytes at position LINE_LIMIT or later are skipped.
// Rate: one byte per cycle while s_tready is high; the result is registered in the
// cycle after the last byte is taken, and s_tready only drops while a result is held
// there with m_tready low.
module log_tag_denylist_filter_core #(
    parameter int TAG_LIMIT    = 32,
    parameter int DENY_ENTRIES = 4,
    parameter int LINE_LIMIT   = 255
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] line_byte
    input  logic       s_tlast,   // line_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] blocked, [1] tag_found, [3:2] matched_entry, rest 0
);

    localparam int ACTIVE_ROWS = (DENY_ENTRIES < ltdf_pkg::DENY_ROWS) ?
                                 DENY_ENTRIES : ltdf_pkg::DENY_ROWS;
    localparam int TAG_W = $clog2(TAG_LIMIT + 1);
    localparam int CNT_W = $clog2(LINE_LIMIT + 1);

    ltdf_pkg::phase_t phase_reg, phase_next;
    logic [TAG_W-1:0] tag_offset_reg, tag_offset_next;
    logic [ACTIVE_ROWS-1:0] flags_reg, flags_next;
    logic decided_blocked_reg, decided_blocked_next;
    logic [ltdf_pkg::ENTRY_W-1:0] decided_entry_reg, decided_entry_next;
    logic decided_found_reg, decided_found_next;
    logic [CNT_W-1:0] byte_count_reg, byte_count_next;

    logic m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg, m_tdata_next;

    logic s_accept;
    logic scan;
    logic term;
    logic [TAG_W-1:0] tag_inc;

    ltdf_pkg::phase_t scan_phase;
    logic [TAG_W-1:0] scan_offset;
    logic [ACTIVE_ROWS-1:0] scan_flags;
    logic scan_blocked;
    logic [ltdf_pkg::ENTRY_W-1:0] scan_entry;
    logic scan_found;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign scan     = byte_count_reg < CNT_W'(LINE_LIMIT);
    assign term     = ltdf_pkg::is_terminator(s_tdata);
    assign tag_inc  = tag_offset_reg + TAG_W'(1);

    // phase after this byte, before the end-of-line clear
    always_comb
    begin
        scan_phase = phase_reg;
        if (scan)
        begin
            case (phase_reg)
                ltdf_pkg::PH_SEEK_PAREN:
                begin
                    if (s_tdata == ltdf_pkg::CH_RPAREN)
                        scan_phase = ltdf_pkg::PH_SAW_PAREN;
                end
                ltdf_pkg::PH_SAW_PAREN:
                begin
                    if (s_tdata == ltdf_pkg::CH_SPACE)
                        scan_phase = ltdf_pkg::PH_IN_TAG;
                    else if (s_tdata != ltdf_pkg::CH_RPAREN)
                        scan_phase = ltdf_pkg::PH_SEEK_PAREN;
                end
                ltdf_pkg::PH_IN_TAG:
                begin
                    if (term || tag_inc >= TAG_W'(TAG_LIMIT))
                        scan_phase = ltdf_pkg::PH_DONE;
                end
                default:
                    scan_phase = phase_reg;
            endcase
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        if (s_accept)
            phase_next = s_tlast ? ltdf_pkg::PH_SEEK_PAREN : scan_phase;
    end

    // tag offset, prefix flags and decision for this byte
    always_comb
    begin
        scan_offset  = tag_offset_reg;
        scan_flags   = flags_reg;
        scan_blocked = decided_blocked_reg;
        scan_entry   = decided_entry_reg;
        scan_found   = decided_found_reg;
        if (scan && phase_reg == ltdf_pkg::PH_SAW_PAREN && s_tdata == ltdf_pkg::CH_SPACE)
        begin
            scan_offset = '0;
            scan_flags  = '1;
        end
        else if (scan && phase_reg == ltdf_pkg::PH_IN_TAG)
        begin
            if (term)
            begin
                if (tag_offset_reg != '0)
                begin
                    scan_found = 1'b1;
                    // walk down so the lowest matching entry wins
                    for (int k = ACTIVE_ROWS - 1; k >= 0; k--)
                    begin
                        if (flags_reg[k] && ltdf_pkg::DENY_LEN[k] ==
                            ltdf_pkg::POS_W'(tag_offset_reg))
                        begin
                            scan_blocked = 1'b1;
                            scan_entry   = ltdf_pkg::ENTRY_W'(k);
                        end
                    end
                end
            end
            else
            begin
                for (int k = 0; k < ACTIVE_ROWS; k++)
                begin
                    if (!ltdf_pkg::deny_keep(ltdf_pkg::ENTRY_W'(k),
                                             ltdf_pkg::POS_W'(tag_offset_reg), s_tdata))
                        scan_flags[k] = 1'b0;
                end
                scan_offset = tag_inc;
            end
        end
    end

    always_comb
    begin
        tag_offset_next      = tag_offset_reg;
        flags_next           = flags_reg;
        decided_blocked_next = decided_blocked_reg;
        decided_entry_next   = decided_entry_reg;
        decided_found_next   = decided_found_reg;
        byte_count_next      = byte_count_reg;
        if (s_accept)
        begin
            if (s_tlast)
            begin
                tag_offset_next      = '0;
                flags_next           = '1;
                decided_blocked_next = 1'b0;
                decided_entry_next   = '0;
                decided_found_next   = 1'b0;
                byte_count_next      = '0;
            end
            else
            begin
                tag_offset_next      = scan_offset;
                flags_next           = scan_flags;
                decided_blocked_next = scan_blocked;
                decided_entry_next   = scan_entry;
                decided_found_next   = scan_found;
                if (scan)
                    byte_count_next = byte_count_reg + CNT_W'(1);
            end
        end
    end

    // result word register
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        if (s_accept && s_tlast)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {4'b0000,
                             scan_blocked ? scan_entry : ltdf_pkg::ENTRY_W'(0),
                             scan_found, scan_blocked};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= ltdf_pkg::PH_SEEK_PAREN;
            tag_offset_reg      <= '0;
            flags_reg           <= '1;
            decided_blocked_reg <= 1'b0;
            decided_entry_reg   <= '0;
            decided_found_reg   <= 1'b0;
            byte_count_reg      <= '0;
            m_tvalid_reg        <= 1'b0;
        end
        else
        begin
            phase_reg           <= phase_next;
            tag_offset_reg      <= tag_offset_next;
            flags_reg           <= flags_next;
            decided_blocked_reg <= decided_blocked_next;
            decided_entry_reg   <= decided_entry_next;
            decided_found_reg   <= decided_found_next;
            byte_count_reg      <= byte_count_next;
            m_tvalid_reg        <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    a_blocked_needs_tag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!m_tdata[0] || m_tdata[1]))
        else $error("blocked result without a found tag");

    a_entry_zero_when_passed: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[3:2] == '0))
        else $error("nonzero entry on a passed line");

    a_result_follows_line_end: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && s_tlast) |=> m_tvalid)
        else $error("line end gave no result word");

    a_line_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && s_tlast) |=>
        (phase_reg == ltdf_pkg::PH_SEEK_PAREN && byte_count_reg == '0 &&
         !decided_blocked_reg && !decided_found_reg))
        else $error("per-line state not cleared after line end");

    a_decision_only_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        decided_found_reg |-> (phase_reg == ltdf_pkg::PH_DONE))
        else $error("tag decided while still scanning");

endmodule
